>>> rtl/nms3_pkg.sv
// Package: shared constants and register codes for the 3x3 non-maximum suppression core.
`default_nettype none
package nms3_pkg;

	// Default geometry and sample width
	localparam int MAX_WIDTH_DEF   = 4096;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths
	localparam int COORD_BITS   = 12;
	localparam int GEOM_BITS    = 13;
	localparam int THRESH_BITS  = 16;
	localparam int ALLOWED_BITS = 4;
	localparam int ROW_LIMIT    = 4096;

	// Configuration port
	localparam int CFG_ADDR_BITS = 4;
	localparam int CFG_DATA_BITS = 32;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH     = 2'd0,
		REG_IMAGE_HEIGHT    = 2'd1,
		REG_THRESHOLD       = 2'd2,
		REG_ALLOWED_GREATER = 2'd3
	} reg_idx_t;

	// Register reset values
	localparam logic [GEOM_BITS-1:0]    IMAGE_WIDTH_RST     = 13'd640;
	localparam logic [GEOM_BITS-1:0]    IMAGE_HEIGHT_RST    = 13'd480;
	localparam logic [THRESH_BITS-1:0]  THRESHOLD_RST       = 16'd0;
	localparam logic [ALLOWED_BITS-1:0] ALLOWED_GREATER_RST = 4'd0;

	// Result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	// Window positions: row*3 + col, row 0 oldest, col 2 newest
	localparam int WIN_SIZE   = 9;
	localparam int WIN_CENTRE = 4;

endpackage
`default_nettype wire

>>> rtl/nms3_if.sv
// Interfaces: pixel input channel and result output channel.
`default_nettype none
interface nms3_pix_if #(
	parameter int SAMPLE_BITS = nms3_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface nms3_res_if #(
	parameter int SAMPLE_BITS = nms3_pkg::SAMPLE_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic [nms3_pkg::COORD_BITS-1:0]   row;
	logic [nms3_pkg::COORD_BITS-1:0]   column;
	logic                              is_max;
	logic [SAMPLE_BITS-1:0]            magnitude;
	logic                              last;

	modport source (output valid, output row, output column, output is_max,
		output magnitude, output last, input ready);
	modport sink   (input valid, input row, input column, input is_max,
		input magnitude, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/nms3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module nms3_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/nonmax_suppression_3x3_core.sv
// 3x3 non-maximum suppression over a raster pixel stream.
//
// Usage:
//   pixel  : one signed sample per item, raster order, row by row.
//   result : one item per interior pixel (border rows and columns give none):
//            row/column of the centre, is_max, magnitude (0 unless is_max) and
//            last on the final interior pixel of the frame.
//   APB    : image_width @0x0, image_height @0x4, threshold @0x8,
//            allowed_greater @0xC. Write only while no item is in flight.
// Throughput: one pixel per clock unless stalled. The rate is set by the line
//   store, one combined RAM read at acceptance and one write back per pixel.
// Pipeline: after the pixel that completes its window is accepted, a result passes
//   the line store read, window shift and compare before it is presented (the
//   count is made as the item enters the queue).
// Receiver stall: results collect in an 8-entry queue; pixel.ready drops when
//   queued results plus pixels in flight reach 8, and rises again as the
//   queue drains. No result is lost or repeated.
// Reset: counters and window cleared, registers take their defaults. The line
//   store is not cleared; within a frame of fixed width an entry read before it
//   is written only reaches window rows that give no result, so no clearing
//   pass is run.
`default_nettype none
module nonmax_suppression_3x3_core #(
	parameter int MAX_WIDTH   = nms3_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = nms3_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [nms3_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  wire logic [nms3_pkg::CFG_DATA_BITS-1:0]   pwdata,
	output logic      [nms3_pkg::CFG_DATA_BITS-1:0]   prdata,
	output logic                                      pready,
	// channels
	nms3_pix_if.sink                                  pixel,
	nms3_res_if.source                                result
);
	import nms3_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = (CW + 1 > GEOM_BITS) ? CW + 1 : GEOM_BITS;
	localparam int TW  = (SB > THRESH_BITS) ? SB : THRESH_BITS;
	localparam int CNT_BITS = $clog2(WIN_SIZE + 1);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [GEOM_BITS-1:0]    image_width_q;
	logic [GEOM_BITS-1:0]    image_height_q;
	logic [THRESH_BITS-1:0]  threshold_q;
	logic [ALLOWED_BITS-1:0] allowed_q;
	logic                    cfg_wr;
	reg_idx_t                cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
			threshold_q    <= THRESHOLD_RST;
			allowed_q      <= ALLOWED_GREATER_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_IMAGE_WIDTH:     image_width_q  <= pwdata[GEOM_BITS-1:0];
				REG_IMAGE_HEIGHT:    image_height_q <= pwdata[GEOM_BITS-1:0];
				REG_THRESHOLD:       threshold_q    <= pwdata[THRESH_BITS-1:0];
				REG_ALLOWED_GREATER: allowed_q      <= pwdata[ALLOWED_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (cfg_idx)
			REG_IMAGE_WIDTH:     prdata = CFG_DATA_BITS'(image_width_q);
			REG_IMAGE_HEIGHT:    prdata = CFG_DATA_BITS'(image_height_q);
			REG_THRESHOLD:       prdata = CFG_DATA_BITS'(threshold_q);
			REG_ALLOWED_GREATER: prdata = CFG_DATA_BITS'(allowed_q);
			default:             prdata = '0;
		endcase
	end

	// Effective geometry, clamped
	logic [WW-1:0]        w_eff, w_last;
	logic [GEOM_BITS-1:0] h_eff, h_last;

	always_comb begin
		if (WW'(image_width_q) < WW'(3))
			w_eff = WW'(3);
		else if (WW'(image_width_q) > WW'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(image_width_q);
		w_last = w_eff - WW'(1);

		if (image_height_q < GEOM_BITS'(3))
			h_eff = GEOM_BITS'(3);
		else if (image_height_q > GEOM_BITS'(ROW_LIMIT))
			h_eff = GEOM_BITS'(ROW_LIMIT);
		else
			h_eff = image_height_q;
		h_last = h_eff - GEOM_BITS'(1);
	end

	// ---------------------------------------------------------------
	// Acceptance: position counters, magnitude, line store read
	// ---------------------------------------------------------------
	logic [FIFO_CNT_BITS-1:0] fifo_cnt_q;
	logic                     v_s1, v_s2, v_s3;
	logic [FIFO_CNT_BITS-1:0] occupancy;
	logic                     accept;

	// Credit check uses registered state only
	assign occupancy = fifo_cnt_q + FIFO_CNT_BITS'(v_s1) + FIFO_CNT_BITS'(v_s2)
		+ FIFO_CNT_BITS'(v_s3);
	assign pixel.ready = (occupancy < FIFO_CNT_BITS'(FIFO_DEPTH));
	assign accept = pixel.valid & pixel.ready;

	logic [CW-1:0]         col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [WW-1:0]         col_w;
	logic [GEOM_BITS-1:0]  row_w;
	logic                  col_wrap, row_wrap, produce, is_last;
	logic [SB-1:0]         mag;
	logic [WW-1:0]         col_m1;
	logic [GEOM_BITS-1:0]  row_m1;

	always_comb begin
		col_w    = WW'(col_q);
		row_w    = GEOM_BITS'(row_q);
		col_wrap = (col_w >= w_last);
		row_wrap = (row_w >= h_last);
		produce  = (col_w >= WW'(2)) && (col_w <= w_last)
			&& (row_w >= GEOM_BITS'(2)) && (row_w <= h_last);
		is_last  = (row_w == h_last) && (col_w == w_last);
		col_m1   = col_w - WW'(1);
		row_m1   = row_w - GEOM_BITS'(1);
		// |sample|; the most negative value maps to 2^(SB-1)
		mag      = pixel.sample[SB-1] ? SB'(-pixel.sample) : SB'(pixel.sample);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + COORD_BITS'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Line store: {line_above, line_middle} packed in one entry per column.
	// The write back of column c lands in the cycle after its read; the next
	// access to the same column is at least three items later, so no
	// forwarding is needed.
	logic [2*SB-1:0] ls_rdata;
	logic [2*SB-1:0] ls_wdata;
	logic [CW-1:0]   addr_s1;
	logic [SB-1:0]   mag_s1;
	logic            prod_s1, last_s1;
	logic [COORD_BITS-1:0] orow_s1, ocol_s1;
	logic [SB-1:0]   up, mid;

	assign up       = ls_rdata[2*SB-1:SB];
	assign mid      = ls_rdata[SB-1:0];
	assign ls_wdata = {mid, mag_s1};

	nms3_ram #(
		.WIDTH (2*SB),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (v_s1),
		.waddr (addr_s1),
		.wdata (ls_wdata),
		.re    (accept),
		.raddr (col_q),
		.rdata (ls_rdata)
	);

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= col_q;
			mag_s1  <= mag;
			prod_s1 <= produce;
			last_s1 <= is_last;
			orow_s1 <= row_m1[COORD_BITS-1:0];
			ocol_s1 <= col_m1[COORD_BITS-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: window shift with the new column
	// ---------------------------------------------------------------
	logic [SB-1:0] win_q [WIN_SIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_SIZE; k++) begin
				win_q[k] <= '0;
			end
		end else if (v_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= up;
			win_q[5] <= mid;
			win_q[8] <= mag_s1;
		end
	end

	logic                  prod_s2, last_s2;
	logic [COORD_BITS-1:0] orow_s2, ocol_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= prod_s1;
			last_s2 <= last_s1;
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: neighbour compares against the centre (window now updated)
	// ---------------------------------------------------------------
	logic [WIN_SIZE-1:0] gt;
	logic [WIN_SIZE-1:0] gt_s3;
	logic                cand_s3, prod_s3, last_s3;
	logic [SB-1:0]       centre_s3;
	logic [COORD_BITS-1:0] orow_s3, ocol_s3;

	always_comb begin
		for (int k = 0; k < WIN_SIZE; k++) begin
			gt[k] = (k != WIN_CENTRE) && (win_q[k] > win_q[WIN_CENTRE]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			gt_s3     <= gt;
			cand_s3   <= (TW'(win_q[WIN_CENTRE]) >= TW'(threshold_q));
			centre_s3 <= win_q[WIN_CENTRE];
			prod_s3   <= prod_s2;
			last_s3   <= last_s2;
			orow_s3   <= orow_s2;
			ocol_s3   <= ocol_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: count larger neighbours, decide, push into result queue
	// ---------------------------------------------------------------
	logic [CNT_BITS-1:0] n_greater;
	logic                is_max;
	logic                push, pop;

	assign n_greater = CNT_BITS'($countones(gt_s3));
	assign is_max    = cand_s3 && (n_greater <= CNT_BITS'(allowed_q));
	assign push      = v_s3 & prod_s3;
	assign pop       = result.valid & result.ready;

	logic [COORD_BITS-1:0] q_row_q [FIFO_DEPTH];
	logic [COORD_BITS-1:0] q_col_q [FIFO_DEPTH];
	logic                  q_max_q [FIFO_DEPTH];
	logic [SB-1:0]         q_mag_q [FIFO_DEPTH];
	logic                  q_last_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;

	always_ff @(posedge clk) begin
		if (push) begin
			q_row_q[wr_ptr_q]  <= orow_s3;
			q_col_q[wr_ptr_q]  <= ocol_s3;
			q_max_q[wr_ptr_q]  <= is_max;
			q_mag_q[wr_ptr_q]  <= is_max ? centre_s3 : '0;
			q_last_q[wr_ptr_q] <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
			fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
		end
	end

	assign result.valid     = (fifo_cnt_q != '0);
	assign result.row       = q_row_q[rd_ptr_q];
	assign result.column    = q_col_q[rd_ptr_q];
	assign result.is_max    = q_max_q[rd_ptr_q];
	assign result.magnitude = q_mag_q[rd_ptr_q];
	assign result.last      = q_last_q[rd_ptr_q];

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// Credit scheme never lets queue plus pipeline exceed the queue depth
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= FIFO_CNT_BITS'(FIFO_DEPTH))
		else $error("result queue credit exceeded");

	// No push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_cnt_q < FIFO_CNT_BITS'(FIFO_DEPTH)))
		else $error("push into full result queue");

	// Line store write back follows each acceptance in the next cycle
	a_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("line store write back missing");

	// A produced result reaches the queue through stages 1, 2 and 3 after acceptance
	a_push_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && produce) |=> ##2 push)
		else $error("result not pushed on time");

endmodule
`default_nettype wire
